// ===== design/pcp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared widths, outcome and register codes, and types for the point camera
// projection pipeline.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = 64;
  localparam int SUM_W      = 66;
  localparam int MAG_W      = 64;
  localparam int QBITS      = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int PIX_W      = 16;
  localparam int OUTCOME_W  = 2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_INSIDE  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_OUTSIDE = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_SKIPPED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_U_XY    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_U_ZT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_V_XY    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_V_ZT    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W_XY    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W_ZT    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_INVALID = 4'd7;

  typedef struct packed {
    logic [63:0] coef_u_xy;
    logic [63:0] coef_u_zt;
    logic [63:0] coef_v_xy;
    logic [63:0] coef_v_zt;
    logic [63:0] coef_w_xy;
    logic [63:0] coef_w_zt;
    logic [31:0] image_size;
    logic        skip_invalid;
  } cfg_t;

  // control that travels alongside the datapath
  typedef struct packed {
    logic valid;
    logic skip;
    logic wzero;
  } side_t;

  // magnitude of a row sum; bounded below 2^64
  function automatic logic [MAG_W-1:0] sum_mag(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] a;
    a = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
    return a[MAG_W-1:0];
  endfunction

endpackage

// ===== design/pcp_if.sv =====
// ----------------------------------------------------------------------------
// pcp channel interfaces
// Valid/ready channels for points, pixel results and register writes.
// ----------------------------------------------------------------------------
interface pcp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               point_valid;
  modport source (output valid, point_x, point_y, point_z, point_valid, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_valid, output ready);
endinterface

interface pcp_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_col;
  logic [15:0] pixel_row;
  logic [1:0]  outcome;
  modport source (output valid, pixel_col, pixel_row, outcome, input ready);
  modport sink   (input valid, pixel_col, pixel_row, outcome, output ready);
endinterface

interface pcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pcp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pcp_cfg_regs
// Camera matrix, image size and skip mode registers.
// ----------------------------------------------------------------------------
module pcp_cfg_regs import pcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pcp_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
      regs.skip_invalid <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_COEF_U_XY:    regs.coef_u_xy <= cfg.data;
        REG_COEF_U_ZT:    regs.coef_u_zt <= cfg.data;
        REG_COEF_V_XY:    regs.coef_v_xy <= cfg.data;
        REG_COEF_V_ZT:    regs.coef_v_zt <= cfg.data;
        REG_COEF_W_XY:    regs.coef_w_xy <= cfg.data;
        REG_COEF_W_ZT:    regs.coef_w_zt <= cfg.data;
        REG_IMAGE_SIZE:   regs.image_size <= cfg.data[31:0];
        REG_SKIP_INVALID: regs.skip_invalid <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pcp_row_sum.sv =====
// ----------------------------------------------------------------------------
// pcp_row_sum
// One matrix row: three products, then a two-level adder, three stages.
// ----------------------------------------------------------------------------
module pcp_row_sum import pcp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  input  logic signed [COORD_W-1:0] z,
  input  logic [63:0]              coef_xy,
  input  logic [63:0]              coef_zt,
  output logic [SUM_W-1:0]         sum
);

  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [SUM_W-1:0]  k;
  logic [PROD_W:0]          s01;
  logic [SUM_W-1:0]         s2k;
  logic [SUM_W-1:0]         kt;

  assign kt = {{(SUM_W-32){coef_zt[63]}}, coef_zt[63:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= $signed(coef_xy[31:0])  * x;
      p1  <= $signed(coef_xy[63:32]) * y;
      p2  <= $signed(coef_zt[31:0])  * z;
      k   <= $signed(kt) <<< COORD_FRAC_BITS;
      s01 <= {p0[PROD_W-1], p0} + {p1[PROD_W-1], p1};
      s2k <= {{2{p2[PROD_W-1]}}, p2} + k;
      sum <= {s01[PROD_W], s01} + s2k;
    end
  end

endmodule

// ===== design/pcp_div_axis.sv =====
// ----------------------------------------------------------------------------
// pcp_div_axis
// Pipelined restoring divider for one axis: 2*|num| / |w| to 17 bits,
// one quotient bit per stage, with an overflow flag for quotients >= 2^17.
// ----------------------------------------------------------------------------
module pcp_div_axis import pcp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] num_sum,
  input  logic [MAG_W-1:0] den,
  input  logic             den_neg,
  output logic [QBITS-1:0] q2,
  output logic             ovf,
  output logic             mismatch
);

  localparam int REM_W = MAG_W + 1;
  localparam int CMP_W = REM_W + QBITS - 1;

  logic [MAG_W-1:0] num_mag;
  logic             num_neg;
  logic [REM_W-1:0] rem_s [0:QBITS];
  logic [MAG_W-1:0] den_s [0:QBITS];
  logic [QBITS-1:0] q_s   [0:QBITS];
  logic             ovf_s [0:QBITS];
  logic             mis_s [0:QBITS];

  // magnitude and sign of the numerator
  always_ff @(posedge clk) begin
    if (en) begin
      num_mag <= sum_mag(num_sum);
      num_neg <= num_sum[SUM_W-1];
    end
  end

  // quotient of 2n by w reaches 2^17 exactly when (2n >> 17) >= w
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= {num_mag, 1'b0};
      den_s[0] <= den;
      q_s[0]   <= '0;
      ovf_s[0] <= {{(QBITS-1){1'b0}}, num_mag[MAG_W-1:QBITS-1]} >= den;
      mis_s[0] <= num_neg != den_neg;
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_step
    localparam int B = QBITS - 1 - j;
    logic [CMP_W-1:0] rem_x, den_x, diff;
    logic             hit;
    assign rem_x = {{(QBITS-1){1'b0}}, rem_s[j]};
    assign den_x = {{(CMP_W-MAG_W){1'b0}}, den_s[j]} << B;
    assign hit   = rem_x >= den_x;
    assign diff  = rem_x - den_x;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1] <= hit ? diff[REM_W-1:0] : rem_s[j];
        den_s[j+1] <= den_s[j];
        q_s[j+1]   <= {q_s[j][QBITS-2:0], hit};
        ovf_s[j+1] <= ovf_s[j];
        mis_s[j+1] <= mis_s[j];
      end
    end
  end

  assign q2       = q_s[QBITS];
  assign ovf      = ovf_s[QBITS];
  assign mismatch = mis_s[QBITS];

endmodule

// ===== design/point_camera_projection.sv =====
// ----------------------------------------------------------------------------
// point_camera_projection
// Pinhole projection of scan points through a 3x4 camera matrix.
// ----------------------------------------------------------------------------
// throughput: one request per cycle; the divider's 17 quotient-bit stages set most of the depth
// the whole pipeline holds while a finished result is not taken
// reset clears all valid bits and the registers (skip_invalid to one)
module point_camera_projection import pcp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pcp_point_if.sink   point,
  pcp_pixel_if.source pixel,
  pcp_cfg_if.sink     cfg
);

  localparam int LAT = 5 + QBITS;

  cfg_t             regs;
  logic             adv;
  side_t            side [0:LAT-1];
  logic [SUM_W-1:0] u_sum, v_sum, w_sum;
  logic [MAG_W-1:0] w_mag;
  logic             w_neg;
  logic [QBITS-1:0] q2_u, q2_v;
  logic             ovf_u, ovf_v, mis_u, mis_v;
  logic [QBITS:0]   qr_u, qr_v;
  logic [QBITS-1:0] q_u, q_v;
  logic             in_c, in_r;
  logic [OUTCOME_W-1:0] outcome_next;

  pcp_cfg_regs u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  assign adv         = !pixel.valid || pixel.ready;
  assign point.ready = adv;

  pcp_row_sum #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_row_u (
    .clk(clk), .en(adv), .x(point.point_x), .y(point.point_y), .z(point.point_z),
    .coef_xy(regs.coef_u_xy), .coef_zt(regs.coef_u_zt), .sum(u_sum)
  );
  pcp_row_sum #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_row_v (
    .clk(clk), .en(adv), .x(point.point_x), .y(point.point_y), .z(point.point_z),
    .coef_xy(regs.coef_v_xy), .coef_zt(regs.coef_v_zt), .sum(v_sum)
  );
  pcp_row_sum #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_row_w (
    .clk(clk), .en(adv), .x(point.point_x), .y(point.point_y), .z(point.point_z),
    .coef_xy(regs.coef_w_xy), .coef_zt(regs.coef_w_zt), .sum(w_sum)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      w_mag <= sum_mag(w_sum);
      w_neg <= w_sum[SUM_W-1];
    end
  end

  pcp_div_axis u_div_u (
    .clk(clk), .en(adv), .num_sum(u_sum), .den(w_mag), .den_neg(w_neg),
    .q2(q2_u), .ovf(ovf_u), .mismatch(mis_u)
  );
  pcp_div_axis u_div_v (
    .clk(clk), .en(adv), .num_sum(v_sum), .den(w_mag), .den_neg(w_neg),
    .q2(q2_v), .ovf(ovf_v), .mismatch(mis_v)
  );

  // side channel; zero w is found one stage after the row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) side[i].valid <= 1'b0;
    end else if (adv) begin
      side[0].valid <= point.valid;
      side[0].skip  <= !point.point_valid && regs.skip_invalid;
      side[0].wzero <= 1'b0;
      for (int i = 1; i < 3; i++) side[i] <= side[i-1];
      side[3].valid <= side[2].valid;
      side[3].skip  <= side[2].skip;
      side[3].wzero <= sum_mag(w_sum) == '0;
      for (int i = 4; i < LAT; i++) side[i] <= side[i-1];
    end
  end

  // round half away from zero: q = (floor(2n/w) + 1) / 2
  always_comb begin
    qr_u = {1'b0, q2_u} + (QBITS+1)'(1);
    qr_v = {1'b0, q2_v} + (QBITS+1)'(1);
    q_u  = qr_u[QBITS:1];
    q_v  = qr_v[QBITS:1];
    in_c = !ovf_u && !(q_u != '0 && mis_u) && q_u < {1'b0, regs.image_size[15:0]};
    in_r = !ovf_v && !(q_v != '0 && mis_v) && q_v < {1'b0, regs.image_size[31:16]};
    if (side[LAT-1].skip) begin
      outcome_next = OUTCOME_SKIPPED;
    end else if (side[LAT-1].wzero || !(in_c && in_r)) begin
      outcome_next = OUTCOME_OUTSIDE;
    end else begin
      outcome_next = OUTCOME_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (adv) begin
      pixel.valid <= side[LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel.outcome   <= outcome_next;
      pixel.pixel_col <= (outcome_next == OUTCOME_INSIDE) ? q_u[PIX_W-1:0] : '0;
      pixel.pixel_row <= (outcome_next == OUTCOME_INSIDE) ? q_v[PIX_W-1:0] : '0;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !pixel.valid)
    else $error("result valid after reset");
  a_zero_pixel: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.outcome != OUTCOME_INSIDE |->
      pixel.pixel_col == '0 && pixel.pixel_row == '0)
    else $error("non-zero pixel on a result that is not inside");
  a_in_bounds: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.outcome == OUTCOME_INSIDE |->
      pixel.pixel_col < regs.image_size[15:0] && pixel.pixel_row < regs.image_size[31:16])
    else $error("inside result beyond image size");
  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    pixel.valid |-> pixel.outcome == OUTCOME_INSIDE || pixel.outcome == OUTCOME_OUTSIDE
      || pixel.outcome == OUTCOME_SKIPPED)
    else $error("unknown outcome code");

endmodule

// ===== tb/tb_point_camera_projection.sv =====
// ----------------------------------------------------------------------------
// tb_point_camera_projection
// Streams scan points through the projection block under random burst and
// stall patterns, predicts each pixel with an exact wide-integer model of the
// camera matrix, and compares every result field in order.
// ----------------------------------------------------------------------------
module tb_point_camera_projection import pcp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = COORD_FRAC_BITS_DEF;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               ok;
  } point_t;

  typedef struct packed {
    logic [15:0]          col;
    logic [15:0]          row;
    logic [OUTCOME_W-1:0] outcome;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcp_point_if point ();
  pcp_pixel_if pixel ();
  pcp_cfg_if   cfg ();

  point_camera_projection dut (
    .clk   (clk),
    .rst   (rst),
    .point (point.sink),
    .pixel (pixel.source),
    .cfg   (cfg.sink)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [63:0] coef[6];
  logic [31:0] img_size;
  logic        skip_inv;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int     errors = 0;
  int     matched = 0;
  int     cycle = 0;
  int     n_inside = 0, n_outside = 0, n_skipped = 0;

  function automatic logic signed [SUM_W+1:0] row_sum(logic [63:0] xy, logic [63:0] zt,
                                                       point_t p);
    logic signed [SUM_W+1:0] acc;
    acc = $signed(xy[31:0]) * p.x;
    acc += $signed(xy[63:32]) * p.y;
    acc += $signed(zt[31:0]) * p.z;
    acc += $signed(zt[63:32]) * (SUM_W+2)'(1 << FRAC) ;
    return acc;
  endfunction

  // rounded quotient half away from zero; returns 1 if inside [0, lim)
  function automatic bit axis_pos(logic signed [SUM_W+1:0] num, logic [63:0] wm, bit wneg,
                                  logic [15:0] lim, output logic [63:0] q);
    logic [63:0] nm, r;
    bit nneg;
    nneg = num < 0;
    nm = nneg ? 64'(-num) : 64'(num);
    q = nm / wm;
    r = nm % wm;
    if (r >= wm - r) q++;
    if (q != 0 && nneg != wneg) return 0;
    return q < {48'd0, lim};
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t res;
    logic signed [SUM_W+1:0] u, v, w;
    logic [63:0] wm, qc, qr;
    bit wneg, ic, ir;
    res = '0;
    if (!p.ok && skip_inv) begin
      res.outcome = OUTCOME_SKIPPED;
      return res;
    end
    u = row_sum(coef[0], coef[1], p);
    v = row_sum(coef[2], coef[3], p);
    w = row_sum(coef[4], coef[5], p);
    wneg = w < 0;
    wm = wneg ? 64'(-w) : 64'(w);
    res.outcome = OUTCOME_OUTSIDE;
    if (wm == 0) return res;
    ic = axis_pos(u, wm, wneg, img_size[15:0], qc);
    ir = axis_pos(v, wm, wneg, img_size[31:16], qr);
    if (ic && ir) begin
      res.col = qc[15:0];
      res.row = qr[15:0];
      res.outcome = OUTCOME_INSIDE;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
    errors++;
  endtask

  // driver: bursts with random gaps, prediction on acceptance
  int burst_left = 0, gap_left = 0;
  bit in_taken = 1'b0;
  initial begin
    point.valid = 1'b0;
    point.point_x = '0;
    point.point_y = '0;
    point.point_z = '0;
    point.point_valid = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    in_taken <= !rst && point.valid && point.ready;
    if (!rst && point.valid && point.ready) begin
      expected_pixels = {expected_pixels, project_point(pending_points.pop_front())};
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else if (point.valid && !in_taken) begin
      // hold the current request
    end else begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        point.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        burst_left--;
        point.valid <= 1'b1;
        point.point_x <= pending_points[0].x;
        point.point_y <= pending_points[0].y;
        point.point_z <= pending_points[0].z;
        point.point_valid <= pending_points[0].ok;
      end else begin
        point.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and monitor
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (rst) pixel.ready <= 1'b0;
    else if (stall_phase[9:8] == 2'd0) pixel.ready <= 1'b1;
    else if (stall_phase[9:8] == 2'd1) pixel.ready <= ($urandom_range(0, 4) == 0);
    else pixel.ready <= ($urandom_range(0, 2) != 0);
  end
  initial pixel.ready = 1'b0;

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pixel.valid && pixel.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, outcome", 64'(pixel.outcome), 64'd0);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel.outcome !== want.outcome)
          report_mismatch("outcome", 64'(pixel.outcome), 64'(want.outcome));
        if (pixel.pixel_col !== want.col)
          report_mismatch("pixel_col", 64'(pixel.pixel_col), 64'(want.col));
        if (pixel.pixel_row !== want.row)
          report_mismatch("pixel_row", 64'(pixel.pixel_row), 64'(want.row));
        case (want.outcome)
          OUTCOME_INSIDE:  n_inside++;
          OUTCOME_OUTSIDE: n_outside++;
          default:         n_skipped++;
        endcase
        matched++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle >= LIMIT_CYCLES) begin
      $display("timeout with %0d pixels outstanding", expected_pixels.size());
      $display("tb_point_camera_projection: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx < 6) coef[idx] = value;
    else if (idx == REG_IMAGE_SIZE) img_size = value[31:0];
    else if (idx == REG_SKIP_INVALID) skip_inv = value[0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_points.size() > 0 || expected_pixels.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // camera-like matrix: u ~ fx*x + cx*z, w ~ z
  task automatic load_camera(bit skip);
    logic [31:0] f, cx, cy;
    f  = 32'($urandom_range(20, 400)) << 16;
    cx = 32'($urandom_range(0, 640)) << 16;
    cy = 32'($urandom_range(0, 480)) << 16;
    write_reg(REG_COEF_U_XY, {32'($urandom_range(0, 3)) << 12, f});
    write_reg(REG_COEF_U_ZT, {32'($urandom_range(0, 8)), cx});
    write_reg(REG_COEF_V_XY, {f, 32'($urandom_range(0, 3)) << 12});
    write_reg(REG_COEF_V_ZT, {32'($urandom_range(0, 8)), cy});
    write_reg(REG_COEF_W_XY, {32'($urandom_range(0, 7)) << 8, 32'($urandom_range(0, 7)) << 8});
    write_reg(REG_COEF_W_ZT, {32'($urandom_range(0, 2)) << 14, 32'h0001_0000});
    write_reg(REG_IMAGE_SIZE,
              {32'd0, 16'($urandom_range(1, 1200)), 16'($urandom_range(1, 1600))});
    write_reg(REG_SKIP_INVALID, {63'd0, skip});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return 32'($urandom_range(0, 40 << 16)) - (20 << 16);
    endcase
  endfunction

  function automatic point_t scene_point();
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(1 << 14, 30 << 16));
    p.ok = $urandom_range(0, 7) != 0;
    return p;
  endfunction

  function automatic point_t any_point();
    point_t p;
    p.x = $urandom();
    p.y = $urandom();
    p.z = $urandom();
    p.ok = 1'($urandom_range(0, 1));
    return p;
  endfunction

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic ok);
    point_t p;
    p.x = x; p.y = y; p.z = z; p.ok = ok;
    pending_points = {pending_points, p};
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    for (int i = 0; i < 6; i++) coef[i] = '0;
    img_size = '0;
    skip_inv = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: w is zero, invalid points are skipped
    push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
    push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
    wait_idle();

    // identity-like camera: col = x/z, row = y/z, 100x80 image
    write_reg(REG_COEF_U_XY, {32'd0, 32'h0001_0000});
    write_reg(REG_COEF_U_ZT, 64'd0);
    write_reg(REG_COEF_V_XY, {32'h0001_0000, 32'd0});
    write_reg(REG_COEF_V_ZT, 64'd0);
    write_reg(REG_COEF_W_XY, 64'd0);
    write_reg(REG_COEF_W_ZT, {32'd0, 32'h0001_0000});
    write_reg(REG_IMAGE_SIZE, {32'd0, 16'd80, 16'd100});
    write_reg(REG_SKIP_INVALID, 64'd0);
    push_point(32'h000A_0000, 32'h0014_0000, 32'h0001_0000, 1'b1);  // inside
    push_point(32'h0000_8000, 32'h0000_7FFF, 32'h0001_0000, 1'b1);  // half rounds up, just below
    push_point(32'hFFFF_8001, 32'h0000_0000, 32'h0001_0000, 1'b1);  // small negative to zero
    push_point(32'hFFFF_8000, 32'h0000_0000, 32'h0001_0000, 1'b1);  // -0.5 rounds to -1
    push_point(32'h0063_0000, 32'h004F_0000, 32'h0001_0000, 1'b1);  // last pixel
    push_point(32'h0064_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);  // col at width
    push_point(32'h0000_0000, 32'h0050_0000, 32'h0001_0000, 1'b1);  // row at height
    push_point(32'hFFF6_0000, 32'hFFEC_0000, 32'hFFFF_0000, 1'b0);  // both negative
    push_point(32'h1234_5678, 32'h0, 32'h0, 1'b0);                  // zero w, not skipped
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    wait_idle();

    // extreme coefficients and zero image width
    write_reg(REG_COEF_U_XY, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_COEF_U_ZT, 64'h7FFF_FFFF_8000_0000);
    write_reg(REG_COEF_V_XY, 64'h7FFF_FFFF_8000_0000);
    write_reg(REG_COEF_V_ZT, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_COEF_W_XY, 64'h0000_0001_FFFF_FFFF);
    write_reg(REG_COEF_W_ZT, 64'h8000_0000_0000_0001);
    write_reg(REG_IMAGE_SIZE, 64'h0000_0000_FFFF_0000);
    write_reg(REG_SKIP_INVALID, 64'd1);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_point(32'h0, 32'h0, 32'h0, 1'b1);
    push_point(32'h0, 32'h0, 32'h0, 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 8; i++) pending_points = {pending_points, any_point()};
    wait_idle();

    // random phases: mostly camera-like setups, some fully random matrices
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 4 == 3) begin
        for (int r = 0; r < 6; r++)
          write_reg(CFG_IDX_W'(r), {$urandom(), $urandom()});
        write_reg(REG_IMAGE_SIZE, {32'd0, $urandom()});
        write_reg(REG_SKIP_INVALID, {63'd0, 1'($urandom_range(0, 1))});
      end else begin
        load_camera(ph % 2);
      end
      for (int i = 0; i < 150; i++)
        pending_points = {pending_points,
                          (($urandom_range(0, 9) == 0) ? any_point() : scene_point())};
      wait_idle();
    end

    $display("covered %0d pixels: %0d inside, %0d outside, %0d skipped, over 16 setups",
             matched, n_inside, n_outside, n_skipped);
    if (errors == 0) begin
      $display("tb_point_camera_projection: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_point_camera_projection: FAIL");
    end
    $finish;
  end

endmodule
